### hw/rtl/npc_pkg.sv
// Shared types and constants for the nearest palette color search.
// Used by npc_cell, npc_dist and nearest_palette_color; no dependencies.
`default_nettype none

package npc_pkg;

    // One packed RGB888 palette entry: red in 23:16, green in 15:8, blue in 7:0.
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;

    // Largest squared distance is 3 * 255 * 255, which fits in 18 bits.
    localparam int DIST_W = 18;

    // Width of the palette size register and of the result index.
    localparam int SIZE_W  = 9;
    localparam int MATCH_W = 8;

    // Operation codes carried by an input transaction.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Search sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } npc_state_t;

    // Controls from the sequencer to the distance unit.
    typedef struct packed {
        logic clear;   // start of a new search: reset the running best
        logic sample;  // the entry at the head of the ring is inside the search range
    } npc_scan_t;

endpackage

`default_nettype wire

### hw/rtl/npc_cell.sv
// One palette cell of the entry ring: holds a single RGB888 entry.
// Depends on npc_pkg for the entry width.
`default_nettype none

module npc_cell #(
    parameter int CELL_ID = 0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        shift,
    input  wire logic                        load,
    input  wire logic [npc_pkg::MATCH_W-1:0] load_index,
    input  wire logic [npc_pkg::COLOR_W-1:0] load_color,
    input  wire logic [npc_pkg::COLOR_W-1:0] next_color,
    output logic      [npc_pkg::COLOR_W-1:0] color
);
    import npc_pkg::*;

    // Only cells that an 8-bit load index can reach are ever loaded.
    localparam logic REACHABLE = (CELL_ID < (1 << MATCH_W));

    logic               hit;
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;

    assign hit = REACHABLE && (load_index == MATCH_W'(CELL_ID));

    // Rotate with the ring during a search, otherwise take a load aimed here.
    always_comb
    begin
        color_next = color_reg;
        if (shift)
        begin
            color_next = next_color;
        end
        else if (load && hit)
        begin
            color_next = load_color;
        end
    end

    // Entries come out of reset as black.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= '0;
        end
        else
        begin
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

`default_nettype wire

### hw/rtl/npc_dist.sv
// Distance unit at the head of the entry ring: squared RGB distance, then a
// running minimum with the lowest index kept on ties. Depends on npc_pkg.
`default_nettype none

module npc_dist #(
    parameter int IDX_W = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire npc_pkg::npc_scan_t          scan,
    input  wire logic [IDX_W-1:0]            sample_idx,
    input  wire logic [npc_pkg::CHAN_W-1:0]  pix_red,
    input  wire logic [npc_pkg::CHAN_W-1:0]  pix_green,
    input  wire logic [npc_pkg::CHAN_W-1:0]  pix_blue,
    input  wire logic [npc_pkg::COLOR_W-1:0] entry_color,
    output logic      [IDX_W-1:0]            best_idx
);
    import npc_pkg::*;

    logic [CHAN_W-1:0]   ent_red;
    logic [CHAN_W-1:0]   ent_green;
    logic [CHAN_W-1:0]   ent_blue;
    logic [CHAN_W-1:0]   diff_red;
    logic [CHAN_W-1:0]   diff_green;
    logic [CHAN_W-1:0]   diff_blue;
    logic [DIST_W-1:0]   dist_calc;

    logic [DIST_W-1:0]   dist_reg;
    logic [IDX_W-1:0]    dist_idx_reg;
    logic                dist_vld_reg;
    logic [DIST_W-1:0]   best_dist_reg;
    logic [DIST_W-1:0]   best_dist_next;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [IDX_W-1:0]    best_idx_next;

    assign ent_red   = entry_color[23:16];
    assign ent_green = entry_color[15:8];
    assign ent_blue  = entry_color[7:0];

    // Absolute channel differences.
    assign diff_red   = (pix_red   > ent_red)   ? pix_red   - ent_red   : ent_red   - pix_red;
    assign diff_green = (pix_green > ent_green) ? pix_green - ent_green : ent_green - pix_green;
    assign diff_blue  = (pix_blue  > ent_blue)  ? pix_blue  - ent_blue  : ent_blue  - pix_blue;

    // Sum of the three squares; the differences are widened before squaring.
    assign dist_calc = (DIST_W'(diff_red) * DIST_W'(diff_red))
                     + (DIST_W'(diff_green) * DIST_W'(diff_green))
                     + (DIST_W'(diff_blue) * DIST_W'(diff_blue));

    // First stage: register the distance with its entry index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_vld_reg <= 1'b0;
        end
        else
        begin
            dist_vld_reg <= scan.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg     <= dist_calc;
        dist_idx_reg <= sample_idx;
    end

    // Second stage: strict compare, so an equal distance keeps the earlier index.
    always_comb
    begin
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        if (scan.clear)
        begin
            best_dist_next = '1;
            best_idx_next  = '0;
        end
        else if (dist_vld_reg && (dist_reg < best_dist_reg))
        begin
            best_dist_next = dist_reg;
            best_idx_next  = dist_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
    end

    assign best_idx = best_idx_reg;

endmodule

`default_nettype wire

### hw/rtl/nearest_palette_color.sv
// Nearest palette color search: a ring of PALETTE_DEPTH cells rotates past one
// distance unit. A load never raises busy, so the block is ready again at once. A
// lookup keeps busy high for one ring rotation plus the compare stage; done pulses
// in the same cycle in which busy falls, and a new lookup is taken only while busy
// is low. The receiver cannot stall. Reset (rst_n, async, low) sets every entry to
// black, palette_size to 256 and the sequencer to idle.
`default_nettype none

module nearest_palette_color #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        operation,
    input  wire logic [npc_pkg::MATCH_W-1:0] entry_index,
    input  wire logic [npc_pkg::CHAN_W-1:0]  red,
    input  wire logic [npc_pkg::CHAN_W-1:0]  green,
    input  wire logic [npc_pkg::CHAN_W-1:0]  blue,
    output logic                             done,
    output logic      [npc_pkg::MATCH_W-1:0] match_index,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [npc_pkg::SIZE_W-1:0]  cfg_data
);
    import npc_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_DEPTH);
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(PALETTE_DEPTH - 1);

    npc_state_t          state_reg;
    npc_state_t          state_next;
    logic [IDX_W-1:0]    step_reg;
    logic [IDX_W-1:0]    step_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [SIZE_W-1:0]   size_reg;
    logic                done_reg;
    logic                done_next;
    logic [CHAN_W-1:0]   pix_red_reg;
    logic [CHAN_W-1:0]   pix_green_reg;
    logic [CHAN_W-1:0]   pix_blue_reg;

    logic                accept;
    logic                load_fire;
    logic                lookup_fire;
    logic                shift;
    npc_scan_t           scan;
    logic [IDX_W-1:0]    best_idx;
    logic [COLOR_W-1:0]  load_color;
    logic [COLOR_W-1:0]  cell_color [PALETTE_DEPTH];

    assign busy        = (state_reg != ST_IDLE);
    assign accept      = start && !busy;
    assign load_fire   = accept && (operation == OP_LOAD);
    assign lookup_fire = accept && (operation == OP_LOOKUP);
    assign load_color  = {red, green, blue};

    // Configuration transactions are always taken; the block is idle by contract.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_data;
        end
    end

    // Search length: zero counts as one, anything above the depth saturates.
    always_comb
    begin
        if (size_reg == '0)
        begin
            count_next = CNT_W'(1);
        end
        else if (32'(size_reg) > 32'(PALETTE_DEPTH))
        begin
            count_next = CNT_W'(PALETTE_DEPTH);
        end
        else
        begin
            count_next = CNT_W'(size_reg);
        end
    end

    // Sequencer next state and outputs.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        shift      = 1'b0;
        scan.clear  = 1'b0;
        scan.sample = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (lookup_fire)
                begin
                    scan.clear = 1'b1;
                    step_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                shift       = 1'b1;
                scan.sample = (CNT_W'(step_reg) < count_reg);
                step_next   = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // Pixel and search length are held for the whole rotation.
    always_ff @(posedge clk)
    begin
        if (lookup_fire)
        begin
            pix_red_reg   <= red;
            pix_green_reg <= green;
            pix_blue_reg  <= blue;
            count_reg     <= count_next;
        end
    end

    // Ring of entry cells; each hands its entry to the one below during a search.
    for (genvar i = 0; i < PALETTE_DEPTH; i++)
    begin : g_cell
        localparam int NEXT_ID = (i + 1) % PALETTE_DEPTH;

        npc_cell #(
            .CELL_ID (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (shift),
            .load       (load_fire),
            .load_index (entry_index),
            .load_color (load_color),
            .next_color (cell_color[NEXT_ID]),
            .color      (cell_color[i])
        );
    end

    // Distance unit watches the head of the ring.
    npc_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .scan        (scan),
        .sample_idx  (step_reg),
        .pix_red     (pix_red_reg),
        .pix_green   (pix_green_reg),
        .pix_blue    (pix_blue_reg),
        .entry_color (cell_color[0]),
        .best_idx    (best_idx)
    );

    assign done        = done_reg;
    assign match_index = MATCH_W'(best_idx);

`ifndef SYNTHESIS
    // The result strobe comes exactly when a lookup releases busy.
    a_done_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result strobe");

    // A result is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // An accepted lookup starts a search; a load never does.
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_LOOKUP) |=> busy)
        else $error("lookup accepted without starting a search");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_LOAD) |=> (!busy && !done))
        else $error("palette load started a search");
`endif

endmodule

`default_nettype wire
